// ----- src/spq_pkg.sv -----
// Shared types and codes for the stable priority queue.
package spq_pkg;

   typedef struct packed {
      logic        mode;
      logic [15:0] priority_req;
      logic [15:0] tag;
   } req_type;

   typedef struct packed {
      logic        head_valid;
      logic [15:0] head_priority;
      logic [15:0] head_tag;
      logic [15:0] popped_tag;
      logic [4:0]  entry_count;
      logic [1:0]  error;
   } rsp_type;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_POP    = 1'b1;

   typedef enum logic [1:0] {
      ERR_OK    = 2'd0,
      ERR_FULL  = 2'd1,
      ERR_EMPTY = 2'd2
   } err_type;

   typedef enum logic [1:0] {
      OP_KEEP   = 2'd0,
      OP_INSERT = 2'd1,
      OP_POP    = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_HOLD = 2'b10
   } state_type;

   typedef struct packed {
      logic    capture;
      op_type  op;
      err_type err;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } status_type;

endpackage

// ----- src/spq_ctrl.sv -----
// Handshake controller: accepts requests, issues queue commands, holds the result valid.
module spq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_mode,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  spq_pkg::status_type status,
   output spq_pkg::cmd_type    cmd
);
   import spq_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   always_comb begin
      req_stall = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            rsp_valid = 1'b0;
         end
         ST_HOLD: begin
            req_stall = rsp_stall;
            rsp_valid = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
            rsp_valid = 1'b0;
         end
      endcase
   end

   assign accept = req_valid && !req_stall;

   // decide the operation from the request and the queue status
   always_comb begin
      cmd.capture = accept;
      cmd.op      = OP_KEEP;
      cmd.err     = ERR_OK;
      if (req_mode == MODE_INSERT) begin
         if (status.full) begin
            cmd.err = ERR_FULL;
         end else begin
            cmd.op = OP_INSERT;
         end
      end else begin
         if (status.empty) begin
            cmd.err = ERR_EMPTY;
         end else begin
            cmd.op = OP_POP;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      priority if (accept) begin
         state_in = ST_HOLD;
      end else if (state_ff == ST_HOLD && !rsp_stall) begin
         state_in = ST_IDLE;
      end else if (state_ff != ST_HOLD && state_ff != ST_IDLE) begin
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/spq_datapath.sv -----
// Sorted entry array with parallel compare, shift insert/pop, and result register.
module spq_datapath #(
   parameter int DEPTH      = 16,
   parameter int PRIO_WIDTH = 16,
   parameter int TAG_WIDTH  = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  spq_pkg::req_type    req,
   input  spq_pkg::cmd_type    cmd,
   output spq_pkg::status_type status,
   output spq_pkg::rsp_type    rsp
);
   import spq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic [PRIO_WIDTH-1:0] prio_ff [DEPTH];
   logic [PRIO_WIDTH-1:0] prio_in [DEPTH];
   logic [TAG_WIDTH-1:0]  tag_ff  [DEPTH];
   logic [TAG_WIDTH-1:0]  tag_in  [DEPTH];
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic [DEPTH-1:0]      stay;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;

   logic [PRIO_WIDTH+15:0] prio_wide;
   logic [TAG_WIDTH+15:0]  tag_wide;
   logic [PRIO_WIDTH-1:0]  new_prio;
   logic [TAG_WIDTH-1:0]   new_tag;
   logic [PRIO_WIDTH+15:0] head_prio_wide;
   logic [TAG_WIDTH+15:0]  head_tag_wide;
   logic [TAG_WIDTH+15:0]  pop_tag_wide;
   logic [CW+4:0]          count_wide;

   // drop bits above the configured widths
   assign prio_wide = {{PRIO_WIDTH{1'b0}}, req.priority_req};
   assign tag_wide  = {{TAG_WIDTH{1'b0}}, req.tag};
   assign new_prio  = prio_wide[PRIO_WIDTH-1:0];
   assign new_tag   = tag_wide[TAG_WIDTH-1:0];

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CW'(DEPTH));

   // an entry stays put when it is held and not above the new priority
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         stay[i] = (CW'(i) < count_ff) && !(prio_ff[i] > new_prio);
      end
   end

   always_comb begin
      prio_in  = prio_ff;
      tag_in   = tag_ff;
      count_in = count_ff;
      unique case (cmd.op)
         OP_INSERT: begin
            if (!stay[0]) begin
               prio_in[0] = new_prio;
               tag_in[0]  = new_tag;
            end
            for (int i = 1; i < DEPTH; i++) begin
               if (!stay[i]) begin
                  if (stay[i-1]) begin
                     prio_in[i] = new_prio;
                     tag_in[i]  = new_tag;
                  end else begin
                     prio_in[i] = prio_ff[i-1];
                     tag_in[i]  = tag_ff[i-1];
                  end
               end
            end
            count_in = count_ff + CW'(1);
         end
         OP_POP: begin
            for (int i = 0; i < DEPTH - 1; i++) begin
               prio_in[i] = prio_ff[i+1];
               tag_in[i]  = tag_ff[i+1];
            end
            count_in = count_ff - CW'(1);
         end
         OP_KEEP: begin
            count_in = count_ff;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   assign head_prio_wide = {16'd0, prio_in[0]};
   assign head_tag_wide  = {16'd0, tag_in[0]};
   assign pop_tag_wide   = {16'd0, tag_ff[0]};
   assign count_wide     = {5'd0, count_in};

   always_comb begin
      rsp_in.head_valid    = (count_in != '0);
      rsp_in.head_priority = rsp_in.head_valid ? head_prio_wide[15:0] : 16'd0;
      rsp_in.head_tag      = rsp_in.head_valid ? head_tag_wide[15:0] : 16'd0;
      rsp_in.popped_tag    = (cmd.op == OP_POP) ? pop_tag_wide[15:0] : 16'd0;
      rsp_in.entry_count   = count_wide[4:0];
      rsp_in.error         = cmd.err;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         prio_ff <= prio_in;
         tag_ff  <= tag_in;
         rsp_ff  <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.capture) begin
         count_ff <= count_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

// ----- src/stable_priority_queue.sv -----
// Top level of the stable priority queue: controller plus sorted-array datapath.
//
// Usage:
//   Request channel (req_valid, req_stall, req_data): each request either
//   inserts an entry (mode insert, with priority and tag) or pops the head.
//   Entries are kept sorted by ascending priority; equal priorities leave
//   in arrival order.
//   Response channel (rsp_valid, rsp_stall, rsp_data): exactly one response
//   per request, giving the head, the entry count after the step, the tag
//   taken by a pop and an error code (full on insert, empty on pop).
//   Latency: the response is valid the cycle after the request is accepted.
//   Throughput: one request per cycle while rsp_stall is low; all slots
//   compare against the new priority in parallel and shift in the same
//   cycle, so the single response register is the only limit.
//   Stall: while a response is held and rsp_stall is high, req_stall is
//   raised and the held response does not change.
//   Reset: synchronous, active high; empties the queue and drops any held
//   response. Entry contents are not cleared; only held slots are read.
module stable_priority_queue #(
   parameter int DEPTH      = 16,
   parameter int PRIO_WIDTH = 16,
   parameter int TAG_WIDTH  = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output spq_pkg::rsp_type rsp_data
);
   import spq_pkg::*;

   cmd_type    cmd;
   status_type status;

   // controller: handshake and choice of operation
   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_data.mode),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: sorted entries, count and response register
   spq_datapath #(
      .DEPTH      (DEPTH),
      .PRIO_WIDTH (PRIO_WIDTH),
      .TAG_WIDTH  (TAG_WIDTH)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req    (req_data),
      .cmd    (cmd),
      .status (status),
      .rsp    (rsp_data)
   );

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the stable priority queue: directed, then random requests.
module tb;
   import spq_pkg::*;

   localparam int QUEUE_DEPTH     = 16;
   localparam int RANDOM_REQUESTS = 1430;
   localparam int LIMIT_CYCLES    = 100000;

   // Shadow copy of the sorted queue. Each accepted request advances the
   // copy and leaves the response it must produce in a FIFO; responses
   // from the block are checked against the oldest entry in that FIFO.
   class queue_shadow;
      logic [15:0] slot_prio [QUEUE_DEPTH];
      logic [15:0] slot_tag  [QUEUE_DEPTH];
      int          held;
      rsp_type     awaited [$];
      int          mismatches;
      int          responses;
      int          inserts;
      int          pops;
      int          full_drops;
      int          empty_pops;
      int          peak;

      function new();
         held       = 0;
         mismatches = 0;
         responses  = 0;
         inserts    = 0;
         pops       = 0;
         full_drops = 0;
         empty_pops = 0;
         peak       = 0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      // Advance the shadow queue by one request and queue the response it gives.
      function void note_request(req_type r);
         rsp_type res;
         int      pos;
         res = '0;
         if (r.mode == MODE_INSERT) begin
            inserts++;
            if (held == QUEUE_DEPTH) begin
               res.error = ERR_FULL;
               full_drops++;
            end else begin
               // land after every entry of lower or equal priority
               pos = held;
               for (int i = held - 1; i >= 0; i--)
                  if (slot_prio[i] > r.priority_req) pos = i;
               for (int i = held; i > pos; i--) begin
                  slot_prio[i] = slot_prio[i - 1];
                  slot_tag[i]  = slot_tag[i - 1];
               end
               slot_prio[pos] = r.priority_req;
               slot_tag[pos]  = r.tag;
               held++;
               if (held > peak) peak = held;
            end
         end else begin
            pops++;
            if (held == 0) begin
               res.error = ERR_EMPTY;
               empty_pops++;
            end else begin
               res.popped_tag = slot_tag[0];
               for (int i = 1; i < held; i++) begin
                  slot_prio[i - 1] = slot_prio[i];
                  slot_tag[i - 1]  = slot_tag[i];
               end
               held--;
            end
         end
         res.head_valid  = (held > 0);
         res.entry_count = 5'(held);
         if (held > 0) begin
            res.head_priority = slot_prio[0];
            res.head_tag      = slot_tag[0];
         end
         awaited = {awaited, res};
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task compare_field(string name, logic [15:0] got, logic [15:0] want);
         if (got !== want)
            report($sformatf("response %0d %s got 0x%0h want 0x%0h",
                             responses, name, got, want));
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            report($sformatf("unexpected response, head 0x%0h count %0d",
                             got.head_tag, got.entry_count));
            return;
         end
         want = awaited.pop_front();
         compare_field("head_valid", got.head_valid, want.head_valid);
         compare_field("head_priority", got.head_priority, want.head_priority);
         compare_field("head_tag", got.head_tag, want.head_tag);
         compare_field("popped_tag", got.popped_tag, want.popped_tag);
         compare_field("entry_count", got.entry_count, want.entry_count);
         compare_field("error", got.error, want.error);
         responses++;
      endtask
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;

   // hold both sides busy with no idling while this is set
   logic        calm   = 1'b0;
   int          cycles = 0;
   queue_shadow board  = new();

   stable_priority_queue uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Stall the response channel about a third of the time, but never in a
   // calm stretch; change only at the falling edge.
   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 33);
      end
   end

   // Sample the response channel at the rising edge; a response moves when
   // valid is high and stall is low.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_data);
   end

   // Watchdog: end the run once the cycle count passes LIMIT_CYCLES.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("Timed out after %0d cycles with %0d responses awaited",
                  cycles, board.pending());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Present one request and hold it until the block takes it. Called at a
   // falling edge; returns at the falling edge after acceptance, with valid
   // still high so that a following request can go out back to back.
   task automatic send_request(input req_type r);
      while (!calm && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      board.note_request(r);
      @(negedge clock);
   endtask

   task automatic send_fields(input logic mode, input logic [15:0] prio,
                              input logic [15:0] tag);
      req_type r;
      r.mode         = mode;
      r.priority_req = prio;
      r.tag          = tag;
      send_request(r);
   endtask

   // Drop valid and hold off until every awaited response has come back.
   // The wait always advances to a falling edge so valid is not lowered and
   // raised in the same step.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (board.pending() != 0);
   endtask

   initial begin
      req_type r;
      int      issued;
      int      bias;
      int      burst;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: pop on an empty queue, field extremes, ties kept in
      // arrival order, fill to the brim, refused inserts, then drain a few.
      send_fields(MODE_POP, 16'h1234, 16'h5678);
      send_fields(MODE_INSERT, 16'hFFFF, 16'hFFFF);
      send_fields(MODE_INSERT, 16'h0000, 16'h0000);
      send_fields(MODE_INSERT, 16'h0005, 16'h0001);
      send_fields(MODE_INSERT, 16'h0005, 16'h0002);
      send_fields(MODE_INSERT, 16'h0005, 16'h0003);
      send_fields(MODE_POP, 16'hFFFF, 16'hFFFF);
      for (int i = 0; i < 12; i++) begin
         case (i % 3)
            0:       send_fields(MODE_INSERT, 16'hFFFF, 16'hA500 + 16'(i));
            1:       send_fields(MODE_INSERT, 16'h0000, 16'h5A00 + 16'(i));
            default: send_fields(MODE_INSERT, 16'h8000 ^ 16'(i), 16'hC300 + 16'(i));
         endcase
      end
      send_fields(MODE_INSERT, 16'h0000, 16'hDEAD);
      send_fields(MODE_INSERT, 16'hFFFF, 16'hBEEF);
      repeat (3) send_fields(MODE_POP, 16'h0000, 16'h0000);

      // pause the sender until the queue of responses is empty
      wait_drained();

      // Random part: bursts that lean to inserts, to pops, or to neither,
      // so the occupancy swings between empty and full. Priorities mostly
      // come from a narrow range so that ties are common.
      issued = 0;
      while (issued < RANDOM_REQUESTS) begin
         case ($urandom_range(2))
            0:       bias = 85;
            1:       bias = 15;
            default: bias = 50;
         endcase
         burst = $urandom_range(10, 60);
         for (int k = 0; k < burst && issued < RANDOM_REQUESTS; k++) begin
            calm = (issued >= 700 && issued < 1000);
            if (issued % 350 == 349) wait_drained();
            r.mode = ($urandom_range(99) < bias) ? MODE_INSERT : MODE_POP;
            case ($urandom_range(9))
               0:       r.priority_req = 16'h0000;
               1:       r.priority_req = 16'hFFFF;
               2, 3:    r.priority_req = 16'($urandom);
               default: r.priority_req = 16'($urandom_range(7));
            endcase
            r.tag = 16'($urandom);
            send_request(r);
            issued++;
         end
      end
      calm = 1'b0;

      // let the last responses arrive, then allow a few spare cycles for
      // anything unexpected to show up
      wait_drained();
      repeat (8) @(posedge clock);

      if (board.pending() != 0)
         board.report($sformatf("%0d responses never arrived", board.pending()));
      $display("Summary: %0d requests (%0d inserts, %0d pops), %0d responses checked",
               board.inserts + board.pops, board.inserts, board.pops, board.responses);
      $display("Inserts refused when full: %0d, pops on empty: %0d, peak occupancy %0d of %0d",
               board.full_drops, board.empty_pops, board.peak, QUEUE_DEPTH);
      if (board.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

// ----- stable_priority_queue.f -----
src/spq_pkg.sv
src/spq_ctrl.sv
src/spq_datapath.sv
src/stable_priority_queue.sv
dv/tb.sv
